// ===== sv/lcv_pkg.sv =====
// Shared constants, codes and control types for the LED cube voxel engine.
`timescale 1ns / 1ps
package lcv_pkg;

	localparam int GRID_SIZE   = 8;
	localparam int LEVEL_BITS  = 2;
	localparam int COORD_W     = 3;
	localparam int ADDR_W      = 2 * COORD_W;
	localparam int STORE_DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int WORD_W      = GRID_SIZE * LEVEL_BITS;
	localparam int EDGE_W      = 4;
	localparam int WIRE_W      = 5;
	localparam int KIDX_W      = 4;

	localparam logic [KIDX_W-1:0] EDGE_LAST = KIDX_W'(11);

	localparam logic [2:0] FUNC_WRITE = 3'd0;
	localparam logic [2:0] FUNC_READ  = 3'd1;
	localparam logic [2:0] FUNC_PLANE = 3'd2;
	localparam logic [2:0] FUNC_FILL  = 3'd3;
	localparam logic [2:0] FUNC_WIRE  = 3'd4;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD,
		ST_WR,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SRC_POS,
		SRC_WORD,
		SRC_WIRE
	} src_t;

	typedef enum logic [1:0] {
		MODE_VOXEL,
		MODE_READ,
		MODE_PLANE
	} mode_t;

	typedef struct packed {
		logic [2:0]            func;
		logic [COORD_W-1:0]    pos_x;
		logic [COORD_W-1:0]    pos_y;
		logic [COORD_W-1:0]    pos_z;
		logic [LEVEL_BITS-1:0] level;
		logic [1:0]            axis;
		logic [COORD_W-1:0]    plane_index;
		logic [7:0]            fill_byte;
		logic [EDGE_W-1:0]     edge_length;
	} cmd_payload_t;

	typedef struct packed {
		logic              load;
		logic              rd;
		logic              wr;
		logic              fill;
		logic              finish;
		src_t              src;
		mode_t             mode;
		logic [ADDR_W-1:0] widx;
		logic [EDGE_W-1:0] step_i;
		logic [KIDX_W-1:0] edge_k;
	} step_cmd_t;

	typedef struct packed {
		logic [2:0]        func;
		logic              axis_ok;
		logic              edge_zero;
		logic [EDGE_W-1:0] last_i;
	} dp_status_t;

endpackage

// ===== sv/lcv_cmd_if.sv =====
// Command channel: valid/ready handshake with the command fields.
`timescale 1ns / 1ps
interface lcv_cmd_if;
	import lcv_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [2:0]            func;
	logic [COORD_W-1:0]    pos_x;
	logic [COORD_W-1:0]    pos_y;
	logic [COORD_W-1:0]    pos_z;
	logic [LEVEL_BITS-1:0] level;
	logic [1:0]            axis;
	logic [COORD_W-1:0]    plane_index;
	logic [7:0]            fill_byte;
	logic [EDGE_W-1:0]     edge_length;

	modport source (
		output valid, func, pos_x, pos_y, pos_z, level, axis, plane_index, fill_byte,
		       edge_length,
		input  ready
	);
	modport sink (
		input  valid, func, pos_x, pos_y, pos_z, level, axis, plane_index, fill_byte,
		       edge_length,
		output ready
	);
endinterface

// ===== sv/lcv_res_if.sv =====
// Result channel: valid/ready handshake with the read level and clip flag.
`timescale 1ns / 1ps
interface lcv_res_if;
	import lcv_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [LEVEL_BITS-1:0] read_level;
	logic                  clipped;

	modport source (output valid, read_level, clipped, input ready);
	modport sink (input valid, read_level, clipped, output ready);
endinterface

// ===== sv/led_cube_voxel_draw_engine.sv =====
// Top level: 8x8x8 LED cube voxel store with draw commands.
// One command at a time; the result beat sits in an output register, so the next command
// is taken while it waits, as early as the cycle res.valid rises. Work from accept to
// res.valid: write/read one read-modify-write, set plane 64 column read-modify-writes,
// fill 64 writes, wireframe twelve voxel RMWs per step along the edge, others none.
// Reset clears control and marks the store dark.
`timescale 1ns / 1ps
module led_cube_voxel_draw_engine (
	input  logic      clk,
	input  logic      arst_n,
	lcv_cmd_if.sink   cmd,
	lcv_res_if.source res
);
	import lcv_pkg::*;

	cmd_payload_t payload;
	step_cmd_t    step_cmd;
	dp_status_t   status;

	always_comb begin
		payload.func        = cmd.func;
		payload.pos_x       = cmd.pos_x;
		payload.pos_y       = cmd.pos_y;
		payload.pos_z       = cmd.pos_z;
		payload.level       = cmd.level;
		payload.axis        = cmd.axis;
		payload.plane_index = cmd.plane_index;
		payload.fill_byte   = cmd.fill_byte;
		payload.edge_length = cmd.edge_length;
	end

	lcv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.step_cmd  (step_cmd)
	);

	lcv_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload    (payload),
		.step_cmd   (step_cmd),
		.status     (status),
		.read_level (res.read_level),
		.clipped    (res.clipped)
	);

endmodule

// ===== sv/lcv_dpath.sv =====
// Datapath: column store, voxel address generation and read-modify-write merge.
`timescale 1ns / 1ps
module lcv_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcv_pkg::cmd_payload_t         payload,
	input  lcv_pkg::step_cmd_t            step_cmd,
	output lcv_pkg::dp_status_t           status,
	output logic [lcv_pkg::LEVEL_BITS-1:0] read_level,
	output logic                          clipped
);
	import lcv_pkg::*;

	cmd_payload_t          cmd_q;
	logic [WORD_W-1:0]     mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;

	logic [ADDR_W-1:0]     addr_q;
	logic [COORD_W-1:0]    z_q;
	logic                  pclip_q;
	logic [WORD_W-1:0]     rdata_q;
	logic                  rvld_q;
	logic [LEVEL_BITS-1:0] rd_work_q;
	logic                  clip_q;
	logic [LEVEL_BITS-1:0] res_level_q;
	logic                  res_clip_q;

	logic [EDGE_W-1:0]     e_c;
	logic [WIRE_W-1:0]     bx, by, bz, bxi, byi, bzi, bxe, bye, bze;
	logic [WIRE_W-1:0]     wx, wy, wz;
	logic [ADDR_W-1:0]     addr_c;
	logic [COORD_W-1:0]    z_c;
	logic                  pclip_c;

	logic [WORD_W-1:0]     eff;
	logic [WORD_W-1:0]     wdata;
	logic [COORD_W-1:0]    zsel;
	logic                  full, hit, wr_go;

	assign e_c = cmd_q.edge_length - EDGE_W'(1);

	assign status.func      = cmd_q.func;
	assign status.axis_ok   = (cmd_q.axis == AXIS_X) || (cmd_q.axis == AXIS_Y) ||
	                          (cmd_q.axis == AXIS_Z);
	assign status.edge_zero = (cmd_q.edge_length == '0);
	assign status.last_i    = e_c;

	// wireframe corner offsets, 5 bits so points past the far faces are flagged as clipped
	always_comb begin
		bx  = WIRE_W'(cmd_q.pos_x);
		by  = WIRE_W'(cmd_q.pos_y);
		bz  = WIRE_W'(cmd_q.pos_z);
		bxi = bx + WIRE_W'(step_cmd.step_i);
		byi = by + WIRE_W'(step_cmd.step_i);
		bzi = bz + WIRE_W'(step_cmd.step_i);
		bxe = bx + WIRE_W'(e_c);
		bye = by + WIRE_W'(e_c);
		bze = bz + WIRE_W'(e_c);
		case (step_cmd.edge_k)
			4'd0:    begin wx = bxi; wy = by;  wz = bz;  end
			4'd1:    begin wx = bxi; wy = bye; wz = bz;  end
			4'd2:    begin wx = bxi; wy = by;  wz = bze; end
			4'd3:    begin wx = bxi; wy = bye; wz = bze; end
			4'd4:    begin wx = bx;  wy = byi; wz = bz;  end
			4'd5:    begin wx = bxe; wy = byi; wz = bz;  end
			4'd6:    begin wx = bxe; wy = byi; wz = bze; end
			4'd7:    begin wx = bx;  wy = byi; wz = bze; end
			4'd8:    begin wx = bx;  wy = by;  wz = bzi; end
			4'd9:    begin wx = bxe; wy = by;  wz = bzi; end
			4'd10:   begin wx = bxe; wy = bye; wz = bzi; end
			default: begin wx = bx;  wy = bye; wz = bzi; end
		endcase
	end

	always_comb begin
		unique case (step_cmd.src)
			SRC_WORD: begin
				addr_c  = step_cmd.widx;
				z_c     = cmd_q.plane_index;
				pclip_c = 1'b0;
			end
			SRC_WIRE: begin
				addr_c  = {wx[COORD_W-1:0], wy[COORD_W-1:0]};
				z_c     = wz[COORD_W-1:0];
				pclip_c = |{wx[WIRE_W-1:COORD_W], wy[WIRE_W-1:COORD_W],
				            wz[WIRE_W-1:COORD_W]};
			end
			default: begin
				addr_c  = {cmd_q.pos_x, cmd_q.pos_y};
				z_c     = cmd_q.pos_z;
				pclip_c = 1'b0;
			end
		endcase
	end

	// merge of the new level into the column word read in the previous cycle
	always_comb begin
		eff   = rvld_q ? rdata_q : '0;
		zsel  = z_q;
		full  = 1'b0;
		hit   = 1'b1;
		if (step_cmd.mode == MODE_PLANE) begin
			unique case (cmd_q.axis)
				AXIS_X: begin
					hit  = (addr_q[ADDR_W-1:COORD_W] == cmd_q.plane_index);
					full = 1'b1;
				end
				AXIS_Y: begin
					hit  = (addr_q[COORD_W-1:0] == cmd_q.plane_index);
					full = 1'b1;
				end
				default: zsel = cmd_q.plane_index;
			endcase
		end
		wdata = eff;
		wdata[{zsel, 1'b0} +: LEVEL_BITS] = cmd_q.level;
		if (full) begin
			wdata = {GRID_SIZE{cmd_q.level}};
		end
		wr_go = step_cmd.wr && (step_cmd.mode != MODE_READ) && !pclip_q && hit;
	end

	always_ff @(posedge clk) begin
		if (step_cmd.fill) begin
			mem[step_cmd.widx] <= {(WORD_W / 8){cmd_q.fill_byte}};
		end else if (wr_go) begin
			mem[addr_q] <= wdata;
		end
		if (step_cmd.rd) begin
			rdata_q <= mem[addr_c];
		end
	end

	// entries not yet written read as dark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (step_cmd.fill) begin
			vld_q[step_cmd.widx] <= 1'b1;
		end else if (wr_go) begin
			vld_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_cmd.load) begin
			cmd_q     <= payload;
			rd_work_q <= '0;
			clip_q    <= 1'b0;
		end
		if (step_cmd.rd) begin
			addr_q  <= addr_c;
			z_q     <= z_c;
			pclip_q <= pclip_c;
			rvld_q  <= vld_q[addr_c];
		end
		if (step_cmd.wr) begin
			if (pclip_q) begin
				clip_q <= 1'b1;
			end
			if (step_cmd.mode == MODE_READ) begin
				rd_work_q <= eff[{z_q, 1'b0} +: LEVEL_BITS];
			end
		end
		if (step_cmd.finish) begin
			res_level_q <= rd_work_q;
			res_clip_q  <= clip_q;
		end
	end

	assign read_level = res_level_q;
	assign clipped    = res_clip_q;

endmodule

// ===== sv/lcv_ctrl.sv =====
// Controller: command sequencing, sweep counters and result handshake.
`timescale 1ns / 1ps
module lcv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lcv_pkg::dp_status_t status,
	output lcv_pkg::step_cmd_t  step_cmd
);
	import lcv_pkg::*;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] widx_q;
	logic [EDGE_W-1:0] i_q;
	logic [KIDX_W-1:0] k_q;
	logic              out_valid_q;

	logic              accept;
	logic              slot_free;
	logic              last_step;
	logic              widx_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign widx_last = (widx_q == '1);

	always_comb begin
		unique case (status.func)
			FUNC_PLANE: last_step = widx_last;
			FUNC_WIRE:  last_step = (k_q == EDGE_LAST) && (i_q == status.last_i);
			default:    last_step = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (status.func)
					FUNC_WRITE, FUNC_READ: state_d = ST_RD;
					FUNC_PLANE:            state_d = status.axis_ok ? ST_RD : ST_DONE;
					FUNC_FILL:             state_d = ST_FILL;
					FUNC_WIRE:             state_d = status.edge_zero ? ST_DONE : ST_RD;
					default:               state_d = ST_DONE;
				endcase
			end
			ST_RD:   state_d = ST_WR;
			ST_WR:   state_d = last_step ? ST_DONE : ST_RD;
			ST_FILL: begin
				if (widx_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		step_cmd.load   = accept;
		step_cmd.rd     = (state_q == ST_RD);
		step_cmd.wr     = (state_q == ST_WR);
		step_cmd.fill   = (state_q == ST_FILL);
		step_cmd.finish = (state_q == ST_DONE) && slot_free;
		step_cmd.widx   = widx_q;
		step_cmd.step_i = i_q;
		step_cmd.edge_k = k_q;
		unique case (status.func)
			FUNC_READ: begin
				step_cmd.src  = SRC_POS;
				step_cmd.mode = MODE_READ;
			end
			FUNC_PLANE: begin
				step_cmd.src  = SRC_WORD;
				step_cmd.mode = MODE_PLANE;
			end
			FUNC_WIRE: begin
				step_cmd.src  = SRC_WIRE;
				step_cmd.mode = MODE_VOXEL;
			end
			default: begin
				step_cmd.src  = SRC_POS;
				step_cmd.mode = MODE_VOXEL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			widx_q      <= '0;
			i_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DISPATCH) begin
				widx_q <= '0;
				i_q    <= '0;
				k_q    <= '0;
			end else if (state_q == ST_FILL) begin
				widx_q <= widx_q + 1'b1;
			end else if (state_q == ST_WR) begin
				widx_q <= widx_q + 1'b1;
				// k_q visits every cube edge index up to EDGE_LAST, then i_q steps along the edge
				if (k_q == EDGE_LAST) begin
					k_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (step_cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
